FILE: design/peeling_doppler_spectrum_accumulator_assert.svh
// assertion macros shared by the design, clocked on clk and disabled in reset
`ifndef PEELING_DOPPLER_SPECTRUM_ACCUMULATOR_ASSERT_SVH
`define PEELING_DOPPLER_SPECTRUM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define PDSA_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define PDSA_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: design/pdsa_pkg.sv
package pdsa_pkg;

  localparam int NUM_BINS = 1024;
  localparam int BIN_W    = $clog2(NUM_BINS);

  // shared divider sizes
  localparam int DVD_W  = 66;
  localparam int DVS_W  = 50;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  // signed doppler factor width, Q.31
  localparam int DOP_W = 51;

  localparam logic [DVD_W-1:0] LIGHT_SIXTEENTHS = 66'd47966793280000;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_READ    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_BETA_SCALE  = 3'd0,
    CFG_OBS_COSINE  = 3'd1,
    CFG_WINDOW_LOW  = 3'd2,
    CFG_WINDOW_HIGH = 3'd3,
    CFG_INV_BIN_W   = 3'd4,
    CFG_FLUX_SCALE  = 3'd5,
    CFG_LUM_SCALE   = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_BETA,
    S_PKT,
    S_OBS,
    S_CHK,
    S_DIVWL,
    S_WIN,
    S_IDX,
    S_DIVR,
    S_WGT,
    S_EW,
    S_FHI,
    S_LLO,
    S_LHI,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/pdsa_ram.sv
module pdsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/pdsa_div.sv
module pdsa_div
  import pdsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;

  logic [DVS_W:0] rem_sh;
  logic           qbit;
  logic [DVS_W:0] rem_nxt;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    qbit    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DCNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], qbit};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: design/peeling_doppler_spectrum_accumulator.sv
// Peel-off spectrum accumulator. An add transfer (command 0) forms beta from radius and
// beta_scale, the packet and observer Doppler factors, the weight (D_obs/D_pkt)^2 and the
// wavelength, and adds the scaled weighted energy to one flux bin and to the saturating
// totals; a read transfer (command 1) returns one bin. One result per input transfer. All
// multiplies and divides run on one shared 32x32 multiplier and one shared radix-2 divider
// (66 steps) under a sequencer, an add using the divider twice. After reset a pass zeroes
// all 1024 flux memory entries, during which in_stall is high. Configuration is to be written
// only while idle by the user; the block itself does not enforce this.
`include "peeling_doppler_spectrum_accumulator_assert.svh"

module peeling_doppler_spectrum_accumulator
  import pdsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [31:0]        in_radius,
  input  logic signed [16:0] in_direction_cosine,
  input  logic [31:0]        in_frequency,
  input  logic [31:0]        in_packet_energy,
  input  logic [9:0]         in_read_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [9:0]         out_bin_index,
  output logic [47:0]        out_bin_flux,
  output logic [63:0]        out_luminosity_total,
  output logic [63:0]        out_energy_total,
  output logic [31:0]        out_event_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0]        beta_scale_r;
  logic signed [16:0] obs_cos_r;
  logic [19:0]        win_low_r;
  logic [19:0]        win_high_r;
  logic [31:0]        inv_bin_w_r;
  logic [31:0]        flux_scale_r;
  logic [31:0]        lum_scale_r;

  logic [31:0]        radius_r;
  logic signed [16:0] mu_r;
  logic [31:0]        freq_r;
  logic [31:0]        energy_r;
  logic               rbin_ok_r;
  logic [9:0]         rbin_r;

  logic [BIN_W-1:0]       clr_cnt_r;
  logic [63:0]            prod_r;
  logic [31:0]            mul_a, mul_b;
  logic [31:0]            beta_r;
  logic signed [DOP_W-1:0] dpkt_r, dobs_r;
  logic [45:0]            wl_r;
  logic [BIN_W-1:0]       idx_r;
  logic [47:0]            ew_r;
  logic [31:0]            acc_r;
  logic [47:0]            fc_r;

  logic [63:0] lum_sum_r;
  logic [63:0] energy_sum_r;
  logic [31:0] events_r;

  status_t     res_status_r;
  logic [9:0]  res_bin_r;
  logic [47:0] res_flux_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [9:0]  out_bin_r;
  logic [47:0] out_flux_r;
  logic [63:0] out_lum_r;
  logic [63:0] out_energy_r;
  logic [31:0] out_events_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr;
  logic [47:0]      ram_wdata;
  logic             ram_re;
  logic [BIN_W-1:0] ram_raddr;
  logic [47:0]      ram_rdata;

  logic             accept;
  logic             out_free;
  logic [31:0]      beta_sat;
  logic [17:0]      mu_ext, obs_ext, mu_mag, obs_mag;
  logic [DOP_W-1:0] prod_ext;
  logic signed [DOP_W-1:0] d_new;
  logic [DOP_W-1:0] aobs;
  logic             dpkt_bad;
  logic             wl_out;
  logic [31:0]      idx_full;
  logic             idx_ok;
  logic [31:0]      rbin_full;
  logic             rbin_ok;
  logic [31:0]      ratio;
  logic [31:0]      weight;
  logic [48:0]      flux_sum;
  logic [47:0]      flux_new;
  logic [47:0]      lum_add;
  logic [64:0]      lum_sum;
  logic [64:0]      energy_sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    beta_sat  = (|prod_r[63:48]) ? '1 : prod_r[47:16];
    mu_ext    = {mu_r[16], mu_r};
    obs_ext   = {obs_cos_r[16], obs_cos_r};
    mu_mag    = mu_r[16] ? (18'd0 - mu_ext) : mu_ext;
    obs_mag   = obs_cos_r[16] ? (18'd0 - obs_ext) : obs_ext;
    prod_ext  = DOP_W'(prod_r[48:0]);
    aobs      = dobs_r[DOP_W-1] ? (DOP_W'(0) - dobs_r) : dobs_r;
    dpkt_bad  = dpkt_r[DOP_W-1] || (dpkt_r == '0);
    wl_out    = (wl_r < {26'd0, win_low_r}) || (wl_r >= {26'd0, win_high_r});
    idx_full  = prod_r[63:32];
    idx_ok    = idx_full < 32'(NUM_BINS);
    rbin_full = {22'd0, in_read_bin};
    rbin_ok   = rbin_full < 32'(NUM_BINS);
    ratio     = (|div_rsp.quotient[DVD_W-1:32]) ? '1 : div_rsp.quotient[31:0];
    weight    = (|prod_r[63:48]) ? '1 : prod_r[47:16];
    flux_sum  = {1'b0, ram_rdata} + {1'b0, fc_r};
    flux_new  = flux_sum[48] ? '1 : flux_sum[47:0];
    lum_add   = 48'(acc_r) + prod_r[47:0];
    lum_sum   = {1'b0, lum_sum_r} + 65'(lum_add);
    energy_sum = {1'b0, energy_sum_r} + 65'(ew_r);
  end

  // d = 1 - beta*cos; sign of the cosine picked by state
  always_comb begin
    if ((state_r == S_OBS) ? mu_r[16] : obs_cos_r[16]) begin
      d_new = $signed(DOP_W'(64'd1 << 31) + prod_ext);
    end else begin
      d_new = $signed(DOP_W'(64'd1 << 31) - prod_ext);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '{start: 1'b0, dividend: '0, divisor: '0};
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = flux_new;
    ram_re    = 1'b0;
    ram_raddr = idx_full[BIN_W-1:0];
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_READ) begin
            ram_re    = rbin_ok;
            ram_raddr = rbin_full[BIN_W-1:0];
            state_nxt = S_RD;
          end else begin
            state_nxt = S_BETA;
          end
        end
      end
      S_RD: state_nxt = S_DONE;
      S_BETA: begin
        mul_a     = radius_r;
        mul_b     = beta_scale_r;
        state_nxt = S_PKT;
      end
      S_PKT: begin
        mul_a     = beta_sat;
        mul_b     = 32'(mu_mag);
        state_nxt = S_OBS;
      end
      S_OBS: begin
        mul_a     = beta_r;
        mul_b     = 32'(obs_mag);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((freq_r == '0) || dpkt_bad) begin
          state_nxt = S_DONE;
        end else begin
          div_req   = '{start: 1'b1, dividend: LIGHT_SIXTEENTHS, divisor: DVS_W'(freq_r)};
          state_nxt = S_DIVWL;
        end
      end
      S_DIVWL: begin
        if (div_rsp.done) begin
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        mul_a = 32'(wl_r[19:0] - win_low_r);
        mul_b = inv_bin_w_r;
        state_nxt = wl_out ? S_DONE : S_IDX;
      end
      S_IDX: begin
        if (idx_ok) begin
          ram_re    = 1'b1;
          div_req   = '{start: 1'b1, dividend: DVD_W'({aobs, 16'd0}),
                        divisor: DVS_W'(dpkt_r)};
          state_nxt = S_DIVR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIVR: begin
        mul_a = ratio;
        mul_b = ratio;
        if (div_rsp.done) begin
          state_nxt = S_WGT;
        end
      end
      S_WGT: begin
        mul_a     = energy_r;
        mul_b     = weight;
        state_nxt = S_EW;
      end
      S_EW: begin
        mul_a     = prod_r[47:16];
        mul_b     = flux_scale_r;
        state_nxt = S_FHI;
      end
      S_FHI: begin
        mul_a     = 32'(ew_r[47:32]);
        mul_b     = flux_scale_r;
        state_nxt = S_LLO;
      end
      S_LLO: begin
        mul_a     = ew_r[31:0];
        mul_b     = lum_scale_r;
        state_nxt = S_LHI;
      end
      S_LHI: begin
        mul_a     = 32'(ew_r[47:32]);
        mul_b     = lum_scale_r;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_scale_r <= '0;
      obs_cos_r    <= 17'sd32768;
      win_low_r    <= 20'd48000;
      win_high_r   <= 20'd160000;
      inv_bin_w_r  <= 32'd39268272;
      flux_scale_r <= '1;
      lum_scale_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BETA_SCALE:  beta_scale_r <= cfg_data;
        CFG_OBS_COSINE:  obs_cos_r    <= $signed(cfg_data[16:0]);
        CFG_WINDOW_LOW:  win_low_r    <= cfg_data[19:0];
        CFG_WINDOW_HIGH: win_high_r   <= cfg_data[19:0];
        CFG_INV_BIN_W:   inv_bin_w_r  <= cfg_data;
        CFG_FLUX_SCALE:  flux_scale_r <= cfg_data;
        CFG_LUM_SCALE:   lum_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    case (state_r)
      S_IDLE: begin
        radius_r  <= in_radius;
        mu_r      <= in_direction_cosine;
        freq_r    <= in_frequency;
        energy_r  <= in_packet_energy;
        rbin_ok_r <= rbin_ok;
        rbin_r    <= in_read_bin;
      end
      S_RD: begin
        res_status_r <= STAT_READ;
        res_bin_r    <= rbin_r;
        res_flux_r   <= rbin_ok_r ? ram_rdata : '0;
      end
      S_PKT: beta_r <= beta_sat;
      S_OBS: dpkt_r <= d_new;
      S_CHK: begin
        dobs_r       <= d_new;
        res_status_r <= STAT_INVALID;
        res_bin_r    <= '0;
        res_flux_r   <= '0;
      end
      S_DIVWL: wl_r <= div_rsp.quotient[45:0];
      S_WIN: res_status_r <= STAT_OUTSIDE;
      S_IDX: idx_r <= idx_full[BIN_W-1:0];
      S_EW: ew_r <= prod_r[63:16];
      S_FHI: acc_r <= prod_r[63:32];
      S_LLO: fc_r <= 48'(acc_r) + prod_r[47:0];
      S_LHI: acc_r <= prod_r[63:32];
      S_UPD: begin
        res_status_r <= STAT_ADDED;
        res_bin_r    <= idx_r;
        res_flux_r   <= flux_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lum_sum_r    <= '0;
      energy_sum_r <= '0;
      events_r     <= '0;
    end else if (state_r == S_UPD) begin
      lum_sum_r    <= lum_sum[64] ? '1 : lum_sum[63:0];
      energy_sum_r <= energy_sum[64] ? '1 : energy_sum[63:0];
      if (events_r != '1) begin
        events_r <= events_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_bin_r    <= res_bin_r;
      out_flux_r   <= res_flux_r;
      out_lum_r    <= lum_sum_r;
      out_energy_r <= energy_sum_r;
      out_events_r <= events_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_bin_index        = out_bin_r;
  assign out_bin_flux         = out_flux_r;
  assign out_luminosity_total = out_lum_r;
  assign out_energy_total     = out_energy_r;
  assign out_event_count      = out_events_r;

  pdsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pdsa_ram #(
    .WIDTH (48),
    .DEPTH (NUM_BINS)
  ) u_flux_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `PDSA_ASSERT_IMP(a_ram_write_state, ram_we, (state_r == S_UPD) || (state_r == S_CLR), "flux memory written outside clear or update")
  `PDSA_ASSERT_IMP(a_added_counts, out_valid_r && (out_status_r == STAT_ADDED), out_events_r != '0, "added result with zero event count")
  `PDSA_ASSERT_NXT(a_read_path, accept && (in_command == CMD_READ), state_r == S_RD, "read transfer did not enter read state")
  `PDSA_ASSERT_IMP(a_clear_quiet, state_r == S_CLR, !out_valid_r && !div_rsp.done, "activity during memory clear")

endmodule

FILE: dv/peeling_doppler_spectrum_accumulator_tb.sv
`timescale 1ns / 1ps

module peeling_doppler_spectrum_accumulator_tb;
  import pdsa_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_PER_PHASE = 135;
  localparam logic [63:0] LIGHT = 64'd47966793280000;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

  typedef struct {
    logic               cmd;
    logic [31:0]        radius;
    logic signed [16:0] mu;
    logic [31:0]        freq;
    logic [31:0]        energy;
    logic [9:0]         rbin;
  } packet_t;

  typedef struct {
    status_t     st;
    logic [9:0]  bin;
    logic [47:0] flux;
    logic [63:0] lum;
    logic [63:0] en;
    logic [31:0] cnt;
  } spectrum_t;

  // directed row: a packet plus, where obvious, the status/bin/flux it must give
  typedef struct {
    packet_t     pkt;
    logic        known;
    status_t     st;
    logic [9:0]  bin;
    logic [47:0] flux;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [31:0]        in_radius;
  logic signed [16:0] in_direction_cosine;
  logic [31:0]        in_frequency;
  logic [31:0]        in_packet_energy;
  logic [9:0]         in_read_bin;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [9:0]         out_bin_index;
  logic [47:0]        out_bin_flux;
  logic [63:0]        out_luminosity_total;
  logic [63:0]        out_energy_total;
  logic [31:0]        out_event_count;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  peeling_doppler_spectrum_accumulator i_dut (.*);

  // model copy of registers and state
  logic [31:0]        beta_scale_r;
  logic signed [16:0] obs_cos_r;
  logic [19:0]        win_lo_r;
  logic [19:0]        win_hi_r;
  logic [31:0]        inv_bin_w_r;
  logic [31:0]        flux_scale_r;
  logic [31:0]        lum_scale_r;
  logic [47:0]        flux_mem [NUM_BINS];
  logic [63:0]        lum_sum;
  logic [63:0]        energy_sum;
  logic [31:0]        event_cnt;

  spectrum_t pending_spectra[$];
  int        errors;
  int        cycles;
  bit        calm;
  bit        hold_go;
  int        hold_left;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] scale_q32(logic [63:0] x, logic [31:0] s);
    return (x >> 32) * s + (((x & MASK32) * s) >> 32);
  endfunction

  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // one step of the accumulator; updates the model state
  function automatic spectrum_t accumulate(packet_t p);
    spectrum_t r;
    logic [63:0] beta16, aobs, dvs, q, rem, ratio, weight, ew, wl, idx, nf;
    longint dpkt, dobs;
    r.st = STAT_INVALID;
    r.bin = '0;
    r.flux = '0;
    if (p.cmd == CMD_READ) begin
      r.st = STAT_READ;
      r.bin = p.rbin;
      r.flux = flux_mem[p.rbin];
    end else begin
      beta16 = ({32'b0, p.radius} * {32'b0, beta_scale_r}) >> 16;
      if (beta16 > MASK32) beta16 = MASK32;
      dpkt = 64'sh8000_0000 - longint'(beta16) * longint'(p.mu);
      dobs = 64'sh8000_0000 - longint'(beta16) * longint'(obs_cos_r);
      if (p.freq == 0 || dpkt <= 0) begin
        r.st = STAT_INVALID;
      end else begin
        wl = LIGHT / {32'b0, p.freq};
        if (wl < win_lo_r || wl >= win_hi_r) begin
          r.st = STAT_OUTSIDE;
        end else begin
          idx = ((wl - win_lo_r) * inv_bin_w_r) >> 32;
          if (idx >= NUM_BINS) begin
            r.st = STAT_OUTSIDE;
          end else begin
            aobs = dobs < 0 ? -dobs : dobs;
            dvs = dpkt;
            q = aobs / dvs;
            rem = aobs % dvs;
            if (q >= 65536) begin
              ratio = MASK32;
            end else begin
              for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= dvs) begin
                  rem = rem - dvs;
                  q[0] = 1'b1;
                end
              end
              ratio = q;
            end
            weight = (ratio * ratio) >> 16;
            if (weight > MASK32) weight = MASK32;
            ew = ({32'b0, p.energy} * weight) >> 16;
            nf = flux_mem[idx] + scale_q32(ew, flux_scale_r);
            if (nf > MASK48) nf = MASK48;
            flux_mem[idx] = nf[47:0];
            lum_sum = add_sat64(lum_sum, scale_q32(ew, lum_scale_r));
            energy_sum = add_sat64(energy_sum, ew);
            if (event_cnt != '1) event_cnt = event_cnt + 1;
            r.st = STAT_ADDED;
            r.bin = idx[9:0];
            r.flux = nf[47:0];
          end
        end
      end
    end
    r.lum = lum_sum;
    r.en = energy_sum;
    r.cnt = event_cnt;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    case (idx)
      CFG_BETA_SCALE:  beta_scale_r = d;
      CFG_OBS_COSINE:  obs_cos_r = d[16:0];
      CFG_WINDOW_LOW:  win_lo_r = d[19:0];
      CFG_WINDOW_HIGH: win_hi_r = d[19:0];
      CFG_INV_BIN_W:   inv_bin_w_r = d;
      CFG_FLUX_SCALE:  flux_scale_r = d;
      CFG_LUM_SCALE:   lum_scale_r = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    while (pending_spectra.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // offer one packet; known rows override status, bin and flux
  task automatic offer(packet_t p, bit known, status_t st, logic [9:0] bin, logic [47:0] flux);
    spectrum_t e;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = p.cmd;
    in_radius = p.radius;
    in_direction_cosine = p.mu;
    in_frequency = p.freq;
    in_packet_energy = p.energy;
    in_read_bin = p.rbin;
    do @(posedge clk); while (in_stall);
    e = accumulate(p);
    if (known) begin
      e.st = st;
      e.bin = bin;
      e.flux = flux;
    end
    pending_spectra.push_back(e);
  endtask

  function automatic packet_t random_packet();
    packet_t p;
    logic [63:0] wl;
    int sel;
    p.cmd = ($urandom_range(0, 99) < 15) ? CMD_READ : CMD_ADD;
    p.rbin = 10'($urandom);
    p.energy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
    p.mu = 17'($urandom_range(0, 65536) - 32768);
    case ($urandom_range(0, 3))
      0: p.radius = $urandom;
      1: p.radius = $urandom & 32'hFFFF;
      default: p.radius = $urandom & 32'hFFF;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      p.freq = 0;
    end else if (sel < 15 || win_hi_r <= win_lo_r) begin
      p.freq = $urandom;
    end else begin
      wl = 64'($urandom_range(32'(win_lo_r), 32'(win_hi_r) - 32'd1));
      if (wl < 11200) wl = 11200;
      p.freq = 32'(LIGHT / wl);
    end
    return p;
  endfunction

  // receiver: random stall bursts, a long hold on request, none when calm
  int stall_burst;
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (calm) begin
      out_stall = 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_burst = $urandom_range(0, 4);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    spectrum_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_spectra.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_spectra.pop_front();
        if (out_status != e.st) begin
          $error("status: expected %0d actual %0d", e.st, out_status);
          errors++;
        end
        if (out_bin_index != e.bin) begin
          $error("bin_index: expected %0d actual %0d", e.bin, out_bin_index);
          errors++;
        end
        if (out_bin_flux != e.flux) begin
          $error("bin_flux: expected %0h actual %0h", e.flux, out_bin_flux);
          errors++;
        end
        if (out_luminosity_total != e.lum) begin
          $error("luminosity_total: expected %0h actual %0h", e.lum, out_luminosity_total);
          errors++;
        end
        if (out_energy_total != e.en) begin
          $error("energy_total: expected %0h actual %0h", e.en, out_energy_total);
          errors++;
        end
        if (out_event_count != e.cnt) begin
          $error("event_count: expected %0d actual %0d", e.cnt, out_event_count);
          errors++;
        end
      end
    end
  end

  row_t rows[$];

  function automatic row_t mk(logic cmd, logic [31:0] r, int mu, logic [31:0] f,
                              logic [31:0] en, logic [9:0] rb, bit known = 0,
                              status_t st = STAT_ADDED, logic [9:0] bin = 0);
    row_t w;
    w.pkt.cmd = cmd;
    w.pkt.radius = r;
    w.pkt.mu = 17'(mu);
    w.pkt.freq = f;
    w.pkt.energy = en;
    w.pkt.rbin = rb;
    w.known = known;
    w.st = st;
    w.bin = bin;
    w.flux = '0;
    return w;
  endfunction

  initial begin
    packet_t p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ADD;
    in_radius = '0;
    in_direction_cosine = '0;
    in_frequency = '0;
    in_packet_energy = '0;
    in_read_bin = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BETA_SCALE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    stall_burst = 0;
    beta_scale_r = 0;
    obs_cos_r = 17'sd32768;
    win_lo_r = 48000;
    win_hi_r = 160000;
    inv_bin_w_r = 39268272;
    flux_scale_r = '1;
    lum_scale_r = '1;
    foreach (flux_mem[i]) flux_mem[i] = '0;
    lum_sum = '0;
    energy_sum = '0;
    event_cnt = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // memory clearing pass holds the input off
    do @(posedge clk); while (in_stall);

    // directed part with reset defaults
    rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 10'd0, 1, STAT_READ, 10'd0));
    rows.push_back(mk(CMD_READ, '1, 32768, '1, '1, 10'd1023, 1, STAT_READ, 10'd1023));
    rows.push_back(mk(CMD_ADD, 0, 0, 0, 1, 0, 1, STAT_INVALID));
    rows.push_back(mk(CMD_ADD, 0, 0, 32'd600000000, '1, 0));
    rows.push_back(mk(CMD_ADD, '1, -32768, 32'd299800000, 1, 0));
    rows.push_back(mk(CMD_ADD, 0, 32768, 32'd999308193, '1, 0));
    rows.push_back(mk(CMD_ADD, 0, 0, '1, '1, 0, 1, STAT_OUTSIDE));
    rows.push_back(mk(CMD_ADD, 0, 0, 32'd1, '1, 0, 1, STAT_OUTSIDE));
    rows.push_back(mk(CMD_ADD, 0, 0, 32'd600000000, 0, 0));
    rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 10'd292));
    foreach (rows[i]) begin
      offer(rows[i].pkt, rows[i].known, rows[i].st, rows[i].bin, rows[i].flux);
    end
    @(negedge clk);
    in_valid = 1'b0;
    drain();

    // beta = radius, so packet Doppler factor hits zero and goes negative
    write_reg(CFG_BETA_SCALE, 32'h0001_0000);
    rows.delete();
    rows.push_back(mk(CMD_ADD, 32'h0001_0000, 32768, 32'd600000000, 5, 0, 1, STAT_INVALID));
    rows.push_back(mk(CMD_ADD, '1, 32768, 32'd600000000, 5, 0, 1, STAT_INVALID));
    rows.push_back(mk(CMD_ADD, '1, 0, 32'd600000000, '1, 0));
    rows.push_back(mk(CMD_ADD, '1, -32768, 32'd600000000, '1, 0));
    rows.push_back(mk(CMD_ADD, 32'h8000, -1, 32'd400000000, 32'hAAAA5555, 0));
    rows.push_back(mk(CMD_ADD, 32'h7FFF, 32767, 32'd800000000, 32'h5555AAAA, 0));
    rows.push_back(mk(CMD_ADD, 32'h0001_8000, -32768, 32'd0, 7, 0, 1, STAT_INVALID));
    rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 10'h155));
    rows.push_back(mk(CMD_READ, 0, 0, 0, 0, 10'h2AA));
    foreach (rows[i]) begin
      offer(rows[i].pkt, rows[i].known, rows[i].st, rows[i].bin, rows[i].flux);
    end

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      in_valid = 1'b0;
      drain();
      case (ph)
        0: begin
          write_reg(CFG_BETA_SCALE, 32'h0000_4000);
          write_reg(CFG_OBS_COSINE, 32'h0000_8000);
          write_reg(CFG_WINDOW_LOW, 32'd48000);
          write_reg(CFG_WINDOW_HIGH, 32'd160000);
          write_reg(CFG_INV_BIN_W, 32'd39268272);
          write_reg(CFG_FLUX_SCALE, '1);
          write_reg(CFG_LUM_SCALE, '1);
        end
        1: begin
          write_reg(CFG_BETA_SCALE, '1);
          write_reg(CFG_OBS_COSINE, 32'h0001_8000);
          write_reg(CFG_WINDOW_LOW, 32'd0);
          write_reg(CFG_WINDOW_HIGH, 32'hF_FFFF);
          write_reg(CFG_INV_BIN_W, 32'd4294967);
          write_reg(CFG_FLUX_SCALE, 32'd0);
          write_reg(CFG_LUM_SCALE, 32'd0);
        end
        2: begin
          write_reg(CFG_BETA_SCALE, 32'h0010_0000);
          write_reg(CFG_OBS_COSINE, 32'd0);
          write_reg(CFG_WINDOW_LOW, 32'd100000);
          write_reg(CFG_WINDOW_HIGH, 32'd90000);
          write_reg(CFG_INV_BIN_W, 32'd0);
          write_reg(CFG_FLUX_SCALE, 32'd1);
          write_reg(CFG_LUM_SCALE, 32'h8000_0000);
        end
        default: begin
          write_reg(CFG_BETA_SCALE, 32'h0001_0000);
          write_reg(CFG_OBS_COSINE, 32'h0000_4000);
          write_reg(CFG_WINDOW_LOW, 32'd60000);
          write_reg(CFG_WINDOW_HIGH, 32'd61100);
          write_reg(CFG_INV_BIN_W, '1);
          write_reg(CFG_FLUX_SCALE, '1);
          write_reg(CFG_LUM_SCALE, '1);
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 40) hold_go = 1'b1;
        if (ph == 3 && n == RAND_PER_PHASE - 40) calm = 1'b1;
        p = random_packet();
        offer(p, 0, STAT_ADDED, '0, '0);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
